### rtl/i2r_pkg.sv
// i2r_pkg: shared types, constants and helpers for the integer to radix digits core
// no dependencies

package i2r_pkg;

  // default sizing
  localparam int VALUE_BITS_DEF  = 32;
  localparam int DIGIT_DEPTH_DEF = 32;

  // fixed field widths
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;

  // bits of quotient produced per divider cycle
  localparam int DIV_BITS = 8;

  // base limits
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_ZERO,
    ST_WAIT,
    ST_EMIT
  } i2r_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_zero;
    logic emit_digit;
  } i2r_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step_first;
    logic mag_zero;
    logic full;
    logic count_zero;
    logic idx_zero;
    logic out_free;
  } i2r_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_LIMIT) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_ALPHA + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage

### rtl/integer_to_radix_digits_core.sv
// sequence: the request is taken in idle, then the magnitude is divided by the base, 8 quotient
// bits a cycle, one digit per pass, until the quotient reaches zero or the store is full, then
// the sign is emitted and each digit is read back (store read, output load), most significant first
// throughput: one request at a time, a new one is taken once the last character is loaded
// reset: rst_ni async active low clears controller and output valid; digit store not cleared
// depends on i2r_pkg, i2r_ctrl, i2r_dp

module integer_to_radix_digits_core import i2r_pkg::*; #(
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic        [RADIX_W-1:0]    radix_i,
  // character channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [CHAR_W-1:0]     char_code_o,
  output logic                         last_o
);

  // command and status between sequencer and datapath
  i2r_cmd_t cmd;
  i2r_sts_t sts;

  // sequencer: idle, divide loop, sign, zero digit or digit read-back
  i2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: magnitude and clamped base, radix divider, digit store, output register
  i2r_dp #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

### rtl/i2r_ctrl.sv
// i2r_ctrl: sequencer for the conversion, divide phase then character emission
// depends on i2r_pkg

module i2r_ctrl import i2r_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  i2r_sts_t sts_i,
  output i2r_cmd_t cmd_o
);

  i2r_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.step_first && (sts_i.mag_zero || sts_i.full)) state_d = ST_SIGN;
      end
      ST_SIGN: begin
        if (sts_i.out_free) state_d = sts_i.count_zero ? ST_ZERO : ST_WAIT;
      end
      ST_ZERO: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_WAIT: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = sts_i.idx_zero ? ST_IDLE : ST_WAIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.div_step = !(sts_i.step_first && (sts_i.mag_zero || sts_i.full));
      end
      ST_SIGN: cmd_o.emit_sign  = sts_i.out_free;
      ST_ZERO: cmd_o.emit_zero  = sts_i.out_free;
      ST_WAIT: ;
      ST_EMIT: cmd_o.emit_digit = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/i2r_dp.sv
// i2r_dp: magnitude divider, digit store and output register
// depends on i2r_pkg

module i2r_dp import i2r_pkg::*; #(
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic        [RADIX_W-1:0]    radix_i,
  input  i2r_cmd_t                     cmd_i,
  output i2r_sts_t                     sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [CHAR_W-1:0]     char_code_o,
  output logic                         last_o
);

  localparam int Steps = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int QW    = Steps * DIV_BITS;
  localparam int StepW = (Steps > 1) ? $clog2(Steps) : 1;
  localparam int AW    = $clog2(DIGIT_DEPTH);
  localparam int CntW  = $clog2(DIGIT_DEPTH + 1);

  logic [QW-1:0]      work_q;
  logic [RADIX_W-1:0] rem_q;
  logic [RADIX_W-1:0] base_q;
  logic [StepW-1:0]   step_q;
  logic [CntW-1:0]    count_q;
  logic               neg_q;
  logic [AW-1:0]      rd_idx_q;
  logic [DIGIT_W-1:0] rd_data_q;
  logic [DIGIT_W-1:0] store_q [DIGIT_DEPTH];
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic [VALUE_BITS-1:0] v_u;
  logic [VALUE_BITS-1:0] mag;
  logic [RADIX_W-1:0]    base_clamp;
  logic [RADIX_W-1:0]    rem_nxt;
  logic [DIV_BITS-1:0]   qbits;
  logic [RADIX_W:0]      trial;
  logic                  last_step;
  logic                  out_free;

  assign v_u = value_i;
  assign mag = v_u[VALUE_BITS-1] ? (VALUE_BITS'(0) - v_u) : v_u;

  always_comb begin
    if (radix_i < RADIX_MIN) begin
      base_clamp = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      base_clamp = RADIX_MAX;
    end else begin
      base_clamp = radix_i;
    end
  end

  // restoring division, several quotient bits per cycle on a narrow remainder
  always_comb begin
    rem_nxt = rem_q;
    qbits   = '0;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_nxt, work_q[QW-1-i]};
      if (trial >= {1'b0, base_q}) begin
        trial                = trial - {1'b0, base_q};
        qbits[DIV_BITS-1-i] = 1'b1;
      end
      rem_nxt = trial[RADIX_W-1:0];
    end
  end

  assign last_step = (step_q == StepW'(Steps - 1));
  assign out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q   <= '0;
      rem_q    <= '0;
      base_q   <= RADIX_MIN;
      step_q   <= '0;
      count_q  <= '0;
      neg_q    <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.load) begin
      work_q  <= QW'(mag);
      rem_q   <= '0;
      base_q  <= base_clamp;
      step_q  <= '0;
      count_q <= '0;
      neg_q   <= v_u[VALUE_BITS-1];
    end else if (cmd_i.div_step) begin
      work_q <= (work_q << DIV_BITS) | QW'(qbits);
      if (last_step) begin
        rem_q   <= '0;
        step_q  <= '0;
        count_q <= count_q + CntW'(1);
      end else begin
        rem_q  <= rem_nxt;
        step_q <= step_q + StepW'(1);
      end
    end else if (cmd_i.emit_sign) begin
      rd_idx_q <= AW'(count_q - CntW'(1));
    end else if (cmd_i.emit_digit) begin
      rd_idx_q <= rd_idx_q - AW'(1);
    end
  end

  // digit store, written at the end of each digit and read back in reverse
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && last_step) begin
      store_q[count_q[AW-1:0]] <= rem_nxt;
    end
    rd_data_q <= store_q[rd_idx_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_zero || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= neg_q ? CHAR_MINUS : CHAR_SPACE;
      last_q <= 1'b0;
    end else if (cmd_i.emit_zero) begin
      char_q <= CHAR_ZERO;
      last_q <= 1'b1;
    end else if (cmd_i.emit_digit) begin
      char_q <= digit_char(rd_data_q);
      last_q <= (rd_idx_q == '0);
    end
  end

  assign sts_o.step_first = (step_q == '0);
  assign sts_o.mag_zero   = (work_q == '0);
  assign sts_o.full       = (count_q == CntW'(DIGIT_DEPTH));
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.idx_zero   = (rd_idx_q == '0);
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule
